### hw/rtl/rau_pkg.sv
// Rational arithmetic unit package: widths, payload structs, sequencer states.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam int OperandWidth = 16;
	localparam int MagWidth = 2 * OperandWidth + 1;
	localparam int MagCntWidth = $clog2(MagWidth + 1);

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ZERO_DEN = 2'd1,
		STATUS_DIV_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [15:0]       left_num;
		logic signed [15:0]       left_den;
		logic signed [15:0]       right_num;
		logic signed [15:0]       right_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic signed [31:0] result_den;
		logic [1:0]         status;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_G_START,
		ST_G_WAIT,
		ST_G_STEP,
		ST_DN_START,
		ST_DN_WAIT,
		ST_DD_START,
		ST_DD_WAIT,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_COMB,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### hw/rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: sequencer around one shared divider
// and one multiplier. Depends on rau_pkg and rau_divider.
//
//  channel | direction | payload    | handshake
//  in      | input     | in_item_t  | in_valid / in_stall
//  out     | output    | out_item_t | out_valid / out_stall
//
// One item at a time; in_stall stays high from the transfer until the result leaves.
// Each Euclid step is one run of the shared divider, and each reduction is its Euclid
// steps followed by its two exact divisions. Three reductions, plus the check, product
// and output states, make up the work on each item.
// A zero denominator goes from the check state straight to the output state.
// Reset clears the sequencer. The result holds while out_stall is high.
`default_nettype none
module rational_arithmetic_unit_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rau_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rau_pkg::out_item_t      out_data
);
	import rau_pkg::*;

	localparam int W = MagWidth;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [1:0] phase_q; // 0 left, 1 right, 2 result
	// sign/magnitude working values
	logic          nn_q, dn_q, xn_q, yn_q;
	logic [W-1:0]  nm_q, dm_q, xm_q, ym_q;
	logic          an_q, bn_q, cn_q, den_q;
	logic [W-1:0]  am_q, bm_q, cm_q, dmm_q;
	logic [W-1:0]  p1_q, p2_q;
	logic          p1n_q, p2n_q;
	out_item_t     res_q;

	logic div_start, div_busy;
	logic [W-1:0] div_a, div_b, div_quo, div_rem;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_quo), .remainder(div_rem)
	);

	function automatic logic [W-1:0] mag_of(input logic [15:0] v);
		logic [OperandWidth-1:0] t;
		t = v[OperandWidth-1:0];
		if (t[OperandWidth-1]) t = ~t + 1'b1;
		return W'(t);
	endfunction

	// shared multiplier: 17x17 magnitude at most
	logic [W-1:0] mul_a, mul_b, mul_p;
	logic [2*OperandWidth+1:0] mul_full;
	assign mul_full = mul_a[OperandWidth:0] * mul_b[OperandWidth:0];
	assign mul_p = W'(mul_full);

	always_comb begin
		mul_a = am_q;
		mul_b = dmm_q;
		case (state_q)
			ST_M1: begin
				if (item_q.kind == KIND_MUL) mul_b = cm_q;
			end
			ST_M2: begin
				mul_a = cm_q;
				mul_b = bm_q;
				if (item_q.kind == KIND_MUL || item_q.kind == KIND_DIV) mul_a = bm_q;
				if (item_q.kind == KIND_MUL) mul_b = dmm_q;
				if (item_q.kind == KIND_DIV) mul_b = cm_q;
			end
			ST_COMB: begin
				mul_a = bm_q;
				mul_b = dmm_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHECK;
			ST_CHECK:    state_d = ST_G_START;
			ST_G_START:  state_d = (ym_q == '0) ? ST_DN_START : ST_G_WAIT;
			ST_G_WAIT:   if (!div_busy) state_d = ST_G_START;
			ST_DN_START: state_d = (xm_q == '0) ? ST_G_STEP : ST_DN_WAIT;
			ST_DN_WAIT:  if (!div_busy) state_d = ST_DD_START;
			ST_DD_START: state_d = ST_DD_WAIT;
			ST_DD_WAIT:  if (!div_busy) state_d = ST_G_STEP;
			ST_G_STEP:   state_d = (phase_q == 2'd2) ? ST_OUT :
				(phase_q == 2'd1) ? ST_M1 : ST_G_START;
			ST_M1:       state_d = ST_M2;
			ST_M2:       state_d = ST_COMB;
			ST_COMB:     state_d = ST_G_START;
			ST_OUT:      if (!out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
		if (state_q == ST_CHECK) begin
			if (mag_of(item_q.left_den) == '0 || mag_of(item_q.right_den) == '0)
				state_d = ST_OUT;
		end
		if (state_q == ST_G_STEP && phase_q == 2'd1 && item_q.kind == KIND_DIV
				&& nm_q == '0)
			state_d = ST_OUT;
	end

	always_comb begin
		in_stall = state_q != ST_IDLE;
		out_valid = state_q == ST_OUT;
		out_data = res_q;
		div_start = state_q == ST_G_START && ym_q != '0 ||
			state_q == ST_DN_START && xm_q != '0 || state_q == ST_DD_START;
		div_a = (state_q == ST_DD_START) ? dm_q : (state_q == ST_G_START) ? xm_q : nm_q;
		div_b = (state_q == ST_G_START) ? ym_q : xm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) phase_q <= 2'd0;
			else if (state_q == ST_G_STEP) phase_q <= phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) item_q <= in_data;
			ST_CHECK: begin
				// a set sign bit always comes with a nonzero magnitude
				res_q <= '{result_num: '0, result_den: '0, status: STATUS_ZERO_DEN};
				nn_q <= item_q.left_num[OperandWidth-1]; nm_q <= mag_of(item_q.left_num);
				dn_q <= item_q.left_den[OperandWidth-1]; dm_q <= mag_of(item_q.left_den);
				xn_q <= item_q.left_num[OperandWidth-1]; xm_q <= mag_of(item_q.left_num);
				yn_q <= item_q.left_den[OperandWidth-1]; ym_q <= mag_of(item_q.left_den);
			end
			ST_G_WAIT: if (!div_busy) begin
				xn_q <= yn_q; xm_q <= ym_q;
				ym_q <= div_rem;
				yn_q <= xn_q && div_rem != '0;
			end
			ST_DN_WAIT: if (!div_busy) begin
				nm_q <= div_quo;
				nn_q <= (nn_q != xn_q) && div_quo != '0;
			end
			ST_DD_WAIT: if (!div_busy) begin
				dm_q <= div_quo;
				dn_q <= (dn_q != xn_q) && div_quo != '0;
			end
			ST_G_STEP: begin
				case (phase_q)
					2'd0: begin
						an_q <= nn_q; am_q <= nm_q; bn_q <= dn_q; bm_q <= dm_q;
						nn_q <= item_q.right_num[OperandWidth-1];
						nm_q <= mag_of(item_q.right_num);
						dn_q <= item_q.right_den[OperandWidth-1];
						dm_q <= mag_of(item_q.right_den);
						xn_q <= item_q.right_num[OperandWidth-1];
						xm_q <= mag_of(item_q.right_num);
						yn_q <= item_q.right_den[OperandWidth-1];
						ym_q <= mag_of(item_q.right_den);
					end
					2'd1: begin
						cn_q <= nn_q; cm_q <= nm_q; den_q <= dn_q; dmm_q <= dm_q;
						res_q <= '{result_num: '0, result_den: '0,
							status: STATUS_DIV_ZERO};
					end
					default: begin
						res_q.result_num <= nn_q ? -nm_q[31:0] : nm_q[31:0];
						res_q.result_den <= dn_q ? -dm_q[31:0] : dm_q[31:0];
						res_q.status <= STATUS_OK;
					end
				endcase
			end
			ST_M1: begin
				p1_q <= mul_p;
				p1n_q <= (item_q.kind == KIND_MUL) ? (an_q != cn_q) : (an_q != den_q);
			end
			ST_M2: begin
				p2_q <= mul_p;
				p2n_q <= (item_q.kind == KIND_MUL) ? (bn_q != den_q) :
					(item_q.kind == KIND_DIV) ? (bn_q != cn_q) :
					((cn_q != bn_q) ^ (item_q.kind == KIND_SUB));
			end
			ST_COMB: begin
				if (item_q.kind == KIND_MUL || item_q.kind == KIND_DIV) begin
					nm_q <= p1_q; nn_q <= p1n_q && p1_q != '0;
					dm_q <= p2_q; dn_q <= p2n_q && p2_q != '0;
					xm_q <= p1_q; xn_q <= p1n_q && p1_q != '0;
					ym_q <= p2_q; yn_q <= p2n_q && p2_q != '0;
				end else begin
					// sum of cross products, denominator b*d
					logic [W-1:0] s;
					logic sn;
					if ((p1n_q && p1_q != '0) == (p2n_q && p2_q != '0)) begin
						s = p1_q + p2_q; sn = p1n_q && p1_q != '0;
					end else if (p1_q >= p2_q) begin
						s = p1_q - p2_q; sn = p1n_q;
					end else begin
						s = p2_q - p1_q; sn = p2n_q;
					end
					sn = sn && s != '0;
					nm_q <= s; nn_q <= sn; xm_q <= s; xn_q <= sn;
					dm_q <= mul_p;
					dn_q <= bn_q != den_q;
					ym_q <= mul_p;
					yn_q <= bn_q != den_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/rau_divider.sv
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rau_pkg::MagWidth-1:0]  dividend,
	input  wire logic [rau_pkg::MagWidth-1:0]  divisor,
	output logic                               busy,
	output logic [rau_pkg::MagWidth-1:0]       quotient,
	output logic [rau_pkg::MagWidth-1:0]       remainder
);
	import rau_pkg::*;

	logic [MagCntWidth-1:0] cnt_q;
	logic [MagWidth-1:0]    quo_q, rem_q, dsr_q;
	logic [MagWidth:0]      trial;

	assign trial = {rem_q, quo_q[MagWidth-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= MagCntWidth'(MagWidth);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// shift in next dividend bit, subtract when it fits
			if (!trial[MagWidth]) begin
				rem_q <= trial[MagWidth-1:0];
				quo_q <= {quo_q[MagWidth-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MagWidth-2:0], quo_q[MagWidth-1]};
				quo_q <= {quo_q[MagWidth-2:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

### test/rational_arithmetic_unit_top_test.sv
// Self-checking test of rational_arithmetic_unit_top: directed table then random fractions,
// every result compared with its typed table value or a sign-magnitude fraction calculator. Depends on rau_pkg.
`default_nettype none
module rational_arithmetic_unit_top_test;
	import rau_pkg::*;

	typedef struct {
		bit              neg;
		longint unsigned mag;
	} smag_t;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t result;
	} vector_t;

	localparam int NumRandom = 1630;
	localparam int HoldCycles = 3000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	out_item_t pending_results[$];
	int        sender_idle_pct = 24;
	int        receiver_idle_pct = 69;
	bit        hold_req = 1'b0;
	int        hold_left = 0;
	int        errors = 0;
	int        results_seen = 0;
	int        items_sent = 0;
	int        kind_count[4] = '{0, 0, 0, 0};
	int        status_count[3] = '{0, 0, 0};

	rational_arithmetic_unit_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic smag_t sm(bit neg, longint unsigned mag);
		smag_t r;
		r.mag = mag;
		r.neg = neg && mag != 0;
		return r;
	endfunction

	function automatic smag_t from_operand(logic signed [15:0] v);
		longint x;
		x = v;
		return sm(x < 0, x < 0 ? -x : x);
	endfunction

	function automatic smag_t sm_mul(smag_t a, smag_t b);
		return sm(a.neg != b.neg, a.mag * b.mag);
	endfunction

	function automatic smag_t sm_add(smag_t a, smag_t b);
		if (a.neg == b.neg)
			return sm(a.neg, a.mag + b.mag);
		if (a.mag >= b.mag)
			return sm(a.neg, a.mag - b.mag);
		return sm(b.neg, b.mag - a.mag);
	endfunction

	// Euclid with truncated remainder: remainder keeps the dividend's sign
	function automatic smag_t sm_gcd(smag_t x, smag_t y);
		smag_t r;
		while (y.mag != 0) begin
			r = sm(x.neg, x.mag % y.mag);
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic smag_t sm_div(smag_t n, smag_t g);
		if (g.mag == 0)
			return n;
		return sm(n.neg != g.neg, n.mag / g.mag);
	endfunction

	function automatic void reduce_fraction(ref smag_t n, ref smag_t d);
		smag_t g;
		g = sm_gcd(n, d);
		n = sm_div(n, g);
		d = sm_div(d, g);
	endfunction

	function automatic logic [31:0] to_word(smag_t v);
		logic [31:0] m;
		m = v.mag[31:0];
		return v.neg ? -m : m;
	endfunction

	function automatic out_item_t fraction_result(in_item_t it);
		smag_t     a, b, c, d, n, q, cb;
		out_item_t r;
		r = '0;
		a = from_operand(it.left_num);
		b = from_operand(it.left_den);
		c = from_operand(it.right_num);
		d = from_operand(it.right_den);
		if (b.mag == 0 || d.mag == 0) begin
			r.status = STATUS_ZERO_DEN;
			return r;
		end
		reduce_fraction(a, b);
		reduce_fraction(c, d);
		case (kind_t'(it.kind))
			KIND_ADD: begin
				n = sm_add(sm_mul(a, d), sm_mul(c, b));
				q = sm_mul(b, d);
			end
			KIND_SUB: begin
				cb = sm_mul(c, b);
				n = sm_add(sm_mul(a, d), sm(!cb.neg, cb.mag));
				q = sm_mul(b, d);
			end
			KIND_MUL: begin
				n = sm_mul(a, c);
				q = sm_mul(b, d);
			end
			default: begin
				if (c.mag == 0) begin
					r.status = STATUS_DIV_ZERO;
					return r;
				end
				n = sm_mul(a, d);
				q = sm_mul(b, c);
			end
		endcase
		reduce_fraction(n, q);
		r.result_num = to_word(n);
		r.result_den = to_word(q);
		r.status = STATUS_OK;
		return r;
	endfunction

	function automatic vector_t row(kind_t k, int ln, int ld, int rn, int rd,
			bit typed = 0, int en = 0, int ed = 0, status_t es = STATUS_OK);
		vector_t v;
		v.item.kind = k;
		v.item.left_num = ln[15:0];
		v.item.left_den = ld[15:0];
		v.item.right_num = rn[15:0];
		v.item.right_den = rd[15:0];
		v.typed = typed;
		v.result.result_num = en;
		v.result.result_den = ed;
		v.result.status = es;
		return v;
	endfunction

	function automatic logic signed [15:0] random_operand();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return 16'($urandom);
		if (sel < 8)
			return 16'($urandom_range(40) - 20);
		case ($urandom_range(4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd1;
			3: return -16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	task automatic offer(in_item_t it, out_item_t expected);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(expected);
		kind_count[it.kind]++;
		items_sent++;
	endtask

	// receiver: random stall, long hold-off on request, field-by-field compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					if (out_data.result_num !== pending_results[0].result_num
							|| out_data.result_den !== pending_results[0].result_den
							|| out_data.status !== pending_results[0].status) begin
						$display("%0t: mismatch expected %p actual %p", $time,
							pending_results[0], out_data);
						errors++;
					end
					if (out_data.status <= STATUS_DIV_ZERO)
						status_count[out_data.status]++;
					void'(pending_results.pop_front());
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_left <= HoldCycles;
				hold_req <= 1'b0;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= hold_left > 1;
			end else begin
				out_stall <= $urandom_range(99) < receiver_idle_pct;
			end
		end
	end

	initial begin
		#400_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		vector_t   directed[$];
		in_item_t  it;
		int        waited;
		directed.push_back(row(KIND_ADD, 1, 2, 1, 3, 1, 5, 6, STATUS_OK));
		directed.push_back(row(KIND_ADD, 1, 0, 1, 1, 1, 0, 0, STATUS_ZERO_DEN));
		directed.push_back(row(KIND_MUL, 3, 4, 5, 0, 1, 0, 0, STATUS_ZERO_DEN));
		directed.push_back(row(KIND_DIV, 7, 0, 0, 0, 1, 0, 0, STATUS_ZERO_DEN));
		directed.push_back(row(KIND_DIV, 1, 2, 0, 5, 1, 0, 0, STATUS_DIV_ZERO));
		directed.push_back(row(KIND_SUB, 0, 1, 0, 0, 1, 0, 0, STATUS_ZERO_DEN));
		directed.push_back(row(KIND_MUL, 1, 2, 2, 3, 1, 1, 3, STATUS_OK));
		directed.push_back(row(KIND_ADD, 32767, 1, 32767, 1, 1, 65534, 1, STATUS_OK));
		directed.push_back(row(KIND_SUB, 1, 2, 1, 2));
		directed.push_back(row(KIND_DIV, 3, 4, 9, 8));
		directed.push_back(row(KIND_ADD, 1, -2, 1, 3));
		directed.push_back(row(KIND_SUB, -1, 2, 1, -2));
		directed.push_back(row(KIND_MUL, -32768, 1, -32768, 1));
		directed.push_back(row(KIND_DIV, -32768, -32768, 32767, -32768));
		directed.push_back(row(KIND_ADD, 32767, -32768, -32768, 32767));
		directed.push_back(row(KIND_SUB, -32768, 32767, 32767, -32767));
		directed.push_back(row(KIND_MUL, 0, -5, 7, 3));
		directed.push_back(row(KIND_DIV, -32768, 1, -1, 32767));
		directed.push_back(row(KIND_ADD, 0, 7, 0, -3));
		directed.push_back(row(KIND_DIV, -6, -4, -9, 6));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i].item, directed[i].typed ? directed[i].result
				: fraction_result(directed[i].item));
		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom / 3) begin
				sender_idle_pct = 69;
				receiver_idle_pct = 24;
			end
			if (i == 2 * NumRandom / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			// long receiver hold-off so the block backs up into its input
			if (i == NumRandom / 2)
				hold_req = 1'b1;
			it.kind = 2'($urandom);
			it.left_num = random_operand();
			it.left_den = random_operand();
			it.right_num = random_operand();
			it.right_den = random_operand();
			offer(it, fraction_result(it));
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		waited = 0;
		while (waited < 2000) begin
			@(posedge clk);
			waited++;
		end

		$display("Sent %0d fractions (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
			items_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
			results_seen);
		$display("Status seen: ok %0d, zero denominator %0d, divide by zero %0d, errors %0d",
			status_count[0], status_count[1], status_count[2], errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
